### hdl/rmj_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants of the radar measurement Jacobian.
// No dependencies; rmj_mul and radar_measurement_jacobian refer to this package.
package rmj_pkg;

  // Operand chunk width of one hardware multiplier.
  localparam int MUL_BITS = 32;

  // Sign and special-case flags that ride along the long pipeline.
  typedef struct packed {
    logic pn;
    logic qn;
    logic dn;
    logic zero;
  } rmj_flags_t;

endpackage

### hdl/rmj_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the state request and the Jacobian result.
// Depends on nothing; instantiated by the parent of radar_measurement_jacobian.
interface rmj_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_x;
  logic signed [WORD_BITS-1:0] pos_y;
  logic signed [WORD_BITS-1:0] vel_x;
  logic signed [WORD_BITS-1:0] vel_y;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] range_by_px;
  logic signed [WORD_BITS-1:0] range_by_py;
  logic signed [WORD_BITS-1:0] bearing_by_px;
  logic signed [WORD_BITS-1:0] bearing_by_py;
  logic signed [WORD_BITS-1:0] rate_by_px;
  logic signed [WORD_BITS-1:0] rate_by_py;
  logic                        zero_range;

  modport source(output valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                 rate_by_px, rate_by_py, zero_range, input ready);
  modport sink(input valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
               rate_by_px, rate_by_py, zero_range, output ready);
endinterface

### hdl/rmj_delay.sv
`timescale 1ns / 1ps
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// Standalone; used by radar_measurement_jacobian.
module rmj_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  if (DEPTH == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [WIDTH-1:0] tap_r [DEPTH];

    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= din;
        for (int i = 1; i < DEPTH; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end

    assign dout = tap_r[DEPTH-1];
  end

endmodule

### hdl/rmj_mul.sv
`timescale 1ns / 1ps
// Two-stage unsigned multiplier built from registered chunk products.
// Uses rmj_pkg::MUL_BITS as the chunk width.
module rmj_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int CW  = rmj_pkg::MUL_BITS;
  localparam int NA  = (AW + CW - 1) / CW;
  localparam int NB  = (BW + CW - 1) / CW;
  localparam int NAW = NA * CW;
  localparam int NBW = NB * CW;
  localparam int PW  = NAW + NBW;

  logic [NAW-1:0]    a_ext;
  logic [NBW-1:0]    b_ext;
  logic [2*CW-1:0]   pp_nxt [NA*NB];
  logic [2*CW-1:0]   pp_r   [NA*NB];
  logic [PW-1:0]     acc;
  logic [AW+BW-1:0]  p_r;

  assign a_ext = NAW'(a);
  assign b_ext = NBW'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i*NB+j] = a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_r[i*NB+j]) << (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule

### hdl/rmj_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone. The caller guarantees that the quotient fits in QW bits.
module rmj_div #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // Each stage holds the partial remainder, the unused dividend bits with the
  // quotient bits shifted in below them, and its own copy of the divisor.
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] x_r   [QW];
  logic [DW-1:0] d_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_cur;
    logic [QW-1:0] x_cur;
    logic [DW-1:0] d_cur;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_cur = DW'(num >> QW);
      assign x_cur   = num[QW-1:0];
      assign d_cur   = den;
    end else begin : g_next
      assign rem_cur = rem_r[k-1];
      assign x_cur   = x_r[k-1];
      assign d_cur   = d_r[k-1];
    end

    assign trial = {rem_cur, x_cur[QW-1]};
    assign diff  = trial - {1'b0, d_cur};
    assign ge    = (trial >= {1'b0, d_cur});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        x_r[k]   <= {x_cur[QW-2:0], ge};
        d_r[k]   <= d_cur;
      end
    end
  end

  assign quo = x_r[QW-1];

endmodule

### hdl/rmj_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per register stage.
// Standalone; the root is the floor of the square root of x.
module rmj_sqrt #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x,
  output logic [RW-1:0]   root
);

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] xs_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_cur;
    logic [RW-1:0]   root_cur;
    logic [2*RW-1:0] xs_cur;
    logic [RW+3:0]   shifted;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign xs_cur   = x;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign xs_cur   = xs_r[k-1];
    end

    assign shifted = {rem_cur, xs_cur[2*RW-1 -: 2]};
    assign trial   = (RW+4)'({root_cur, 2'b01});
    assign diff    = shifted - trial;
    assign ge      = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
        root_r[k] <= {root_cur[RW-2:0], ge};
        xs_r[k]   <= {xs_cur[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

### hdl/radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// Top level of the radar measurement Jacobian pipeline.
// Depends on rmj_pkg, rmj_if, rmj_delay, rmj_mul, rmj_div and rmj_sqrt.

// The block takes one Cartesian state (px, py, vx, vy, signed fixed point with
// FRAC_BITS fraction bits) per request and returns the six distinct entries of
// the 3x4 radar Jacobian, each truncated toward zero and saturated to a signed
// WORD_BITS word, plus a zero_range flag that is set (with all entries zero)
// when px and py are both zero. It accepts a new request in every cycle and
// delivers one result per cycle while the output is not stalled. The longest
// of the three entry paths is the range-rate path, which chains a multiply,
// a bit-per-stage divide, a square, a second bit-per-stage divide and a
// bit-per-stage square root. Back pressure stalls the whole pipeline in lock
// step, so no request is dropped or repeated while out_rsp.ready is low.
module radar_measurement_jacobian #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rmj_in_if.sink     in_req,
  rmj_out_if.source  out_rsp
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  // Depths of the three entry paths, counted from the stage that holds r^2.
  localparam int LT = 4 + 4 * W + 4 * F;
  localparam int LR = 3 * F + 2;
  localparam int LB = W + 2 * F;
  localparam int NV = 4 + LT;
  localparam int MW = W + 2 * F;
  localparam int FLW = $bits(rmj_pkg::rmj_flags_t);

  // Valid bits travel next to the data.
  logic vld_r [NV];
  logic out_valid_r;

  // The pipeline advances whenever the output register is free or drained.
  logic en;
  assign en = !out_valid_r || out_rsp.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_req.valid;
      for (int i = 1; i < NV; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[NV-1];
    end
  end

  // Stage 1: sign-magnitude form of the inputs. The most negative value keeps
  // its bit pattern, which is its magnitude read as unsigned.
  logic [W-1:0] a_r, b_r, vx_r, vy_r;
  logic         pn_r, qn_r, vxn_r, vyn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pn_r  <= in_req.pos_x[W-1];
      qn_r  <= in_req.pos_y[W-1];
      vxn_r <= in_req.vel_x[W-1];
      vyn_r <= in_req.vel_y[W-1];
      a_r   <= in_req.pos_x[W-1] ? W'(-in_req.pos_x) : W'(in_req.pos_x);
      b_r   <= in_req.pos_y[W-1] ? W'(-in_req.pos_y) : W'(in_req.pos_y);
      vx_r  <= in_req.vel_x[W-1] ? W'(-in_req.vel_x) : W'(in_req.vel_x);
      vy_r  <= in_req.vel_y[W-1] ? W'(-in_req.vel_y) : W'(in_req.vel_y);
    end
  end

  // Stages 2 and 3: px^2, py^2, vx*py and vy*px.
  logic [2*W-1:0] aa_w, bb_w, m1_w, m2_w;

  rmj_mul #(.AW(W), .BW(W)) u_mul_aa (.clk(clk), .en(en), .a(a_r),  .b(a_r), .p(aa_w));
  rmj_mul #(.AW(W), .BW(W)) u_mul_bb (.clk(clk), .en(en), .a(b_r),  .b(b_r), .p(bb_w));
  rmj_mul #(.AW(W), .BW(W)) u_mul_m1 (.clk(clk), .en(en), .a(vx_r), .b(b_r), .p(m1_w));
  rmj_mul #(.AW(W), .BW(W)) u_mul_m2 (.clk(clk), .en(en), .a(vy_r), .b(a_r), .p(m2_w));

  logic [2*W+3:0] side3_w;
  logic [W-1:0]   a3_w, b3_w;
  logic           pn3_w, qn3_w, vxn3_w, vyn3_w;

  rmj_delay #(.WIDTH(2*W+4), .DEPTH(2)) u_dly_side (
    .clk(clk), .en(en),
    .din({a_r, b_r, pn_r, qn_r, vxn_r, vyn_r}),
    .dout(side3_w)
  );
  assign {a3_w, b3_w, pn3_w, qn3_w, vxn3_w, vyn3_w} = side3_w;

  // Stage 4: r^2 and the exact numerator D = vx*py - vy*px in sign-magnitude.
  logic             s1, s2;
  logic [2*W:0]     s_sum;
  logic [2*W-1:0]   dmag_nxt;
  logic             dn_nxt;

  assign s1    = vxn3_w ^ qn3_w;
  assign s2    = !(vyn3_w ^ pn3_w);
  assign s_sum = {1'b0, aa_w} + {1'b0, bb_w};

  always_comb begin
    if (s1 == s2) begin
      dmag_nxt = m1_w + m2_w;
      dn_nxt   = s1;
    end else if (m1_w >= m2_w) begin
      dmag_nxt = m1_w - m2_w;
      dn_nxt   = s1;
    end else begin
      dmag_nxt = m2_w - m1_w;
      dn_nxt   = s2;
    end
  end

  logic [2*W-1:0]       s4_r;
  logic [2*W-1:0]       dmag4_r;
  logic [2*W-1:0]       sq4_r [2];
  logic [W-1:0]         mg4_r [2];
  rmj_pkg::rmj_flags_t  fl4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r       <= s_sum[2*W-1:0];
      dmag4_r    <= dmag_nxt;
      sq4_r[0]   <= aa_w;
      sq4_r[1]   <= bb_w;
      mg4_r[0]   <= a3_w;
      mg4_r[1]   <= b3_w;
      fl4_r.pn   <= pn3_w;
      fl4_r.qn   <= qn3_w;
      fl4_r.dn   <= dn_nxt;
      fl4_r.zero <= (s_sum == '0);
    end
  end

  // r^2 as divisor of the two range-rate divides.
  logic [2*W-1:0] s6_w, s_late_w;

  rmj_delay #(.WIDTH(2*W), .DEPTH(2)) u_dly_s6 (
    .clk(clk), .en(en), .din(s4_r), .dout(s6_w)
  );
  rmj_delay #(.WIDTH(2*W), .DEPTH(W+F+2)) u_dly_slate (
    .clk(clk), .en(en), .din(s6_w), .dout(s_late_w)
  );

  // Per coordinate: index 0 works on px, index 1 on py.
  logic [F:0]     rng [2];
  logic [MW-1:0]  brg [2];
  logic [W+F-1:0] rte [2];

  for (genvar j = 0; j < 2; j++) begin : g_ent
    logic [2*F:0]       rq_w;
    logic [F:0]         rr_w;
    logic [MW-1:0]      bq_w;
    logic [3*W-1:0]     rp_w;
    logic [W+F-1:0]     t_w;
    logic [2*W+2*F-1:0] t2_w;
    logic [2*W+2*F-1:0] q2_w;
    logic [W+F-1:0]     rt_w;

    // Range: sqrt(c^2 * 2^2F / r^2) equals 2^F * c / r.
    rmj_div #(.NW(2*W+2*F), .DW(2*W), .QW(2*F+1)) u_rdiv (
      .clk(clk), .en(en), .num({sq4_r[j], {(2*F){1'b0}}}), .den(s4_r), .quo(rq_w)
    );
    rmj_sqrt #(.RW(F+1)) u_rsqrt (
      .clk(clk), .en(en), .x({1'b0, rq_w}), .root(rr_w)
    );
    rmj_delay #(.WIDTH(F+1), .DEPTH(LT-LR)) u_rdly (
      .clk(clk), .en(en), .din(rr_w), .dout(rng[j])
    );

    // Bearing: c * 2^2F / r^2.
    rmj_div #(.NW(MW), .DW(2*W), .QW(MW)) u_bdiv (
      .clk(clk), .en(en), .num({mg4_r[j], {(2*F){1'b0}}}), .den(s4_r), .quo(bq_w)
    );
    rmj_delay #(.WIDTH(MW), .DEPTH(LT-LB)) u_bdly (
      .clk(clk), .en(en), .din(bq_w), .dout(brg[j])
    );

    // Range rate: t = 2^F * c * |D| / r^2, which stays below 2^(W+F) because
    // |D| <= r * |v|; then sqrt(t^2 / r^2) gives t / r.
    rmj_mul #(.AW(2*W), .BW(W)) u_tmul (
      .clk(clk), .en(en), .a(dmag4_r), .b(mg4_r[j]), .p(rp_w)
    );
    rmj_div #(.NW(3*W+F), .DW(2*W), .QW(W+F)) u_tdiv (
      .clk(clk), .en(en), .num({rp_w, {F{1'b0}}}), .den(s6_w), .quo(t_w)
    );
    rmj_mul #(.AW(W+F), .BW(W+F)) u_tsq (
      .clk(clk), .en(en), .a(t_w), .b(t_w), .p(t2_w)
    );
    rmj_div #(.NW(2*W+2*F), .DW(2*W), .QW(2*W+2*F)) u_qdiv (
      .clk(clk), .en(en), .num(t2_w), .den(s_late_w), .quo(q2_w)
    );
    rmj_sqrt #(.RW(W+F)) u_qsqrt (
      .clk(clk), .en(en), .x(q2_w), .root(rt_w)
    );
    assign rte[j] = rt_w;
  end

  logic [FLW-1:0]      fl_end_w;
  rmj_pkg::rmj_flags_t fl_end;

  rmj_delay #(.WIDTH(FLW), .DEPTH(LT)) u_dly_flags (
    .clk(clk), .en(en), .din(fl4_r), .dout(fl_end_w)
  );
  assign fl_end = fl_end_w;

  // Saturate a magnitude with its sign to a signed word.
  function automatic logic [W-1:0] sat(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] half;
    logic [MW-1:0] m;
    half = MW'(1) << (W - 1);
    if (neg) begin
      m = (mag > half) ? half : mag;
      m = -m;
    end else begin
      m = (mag >= half) ? (half - MW'(1)) : mag;
    end
    return m[W-1:0];
  endfunction

  logic [W-1:0] rbx_nxt, rby_nxt, bbx_nxt, bby_nxt, rtx_nxt, rty_nxt;
  logic [W-1:0] rbx_r, rby_r, bbx_r, bby_r, rtx_r, rty_r;
  logic         zr_r;

  always_comb begin
    rbx_nxt = '0;
    rby_nxt = '0;
    bbx_nxt = '0;
    bby_nxt = '0;
    rtx_nxt = '0;
    rty_nxt = '0;
    if (!fl_end.zero) begin
      rbx_nxt = sat(fl_end.pn, MW'(rng[0]));
      rby_nxt = sat(fl_end.qn, MW'(rng[1]));
      bbx_nxt = sat(!fl_end.qn, brg[1]);
      bby_nxt = sat(fl_end.pn, brg[0]);
      rtx_nxt = sat(fl_end.qn ^ fl_end.dn, MW'(rte[1]));
      rty_nxt = sat(fl_end.pn ^ !fl_end.dn, MW'(rte[0]));
    end
  end

  // Output register: parts the pipeline from the result consumer.
  always_ff @(posedge clk) begin
    if (en) begin
      rbx_r <= rbx_nxt;
      rby_r <= rby_nxt;
      bbx_r <= bbx_nxt;
      bby_r <= bby_nxt;
      rtx_r <= rtx_nxt;
      rty_r <= rty_nxt;
      zr_r  <= fl_end.zero;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.range_by_px   = rbx_r;
  assign out_rsp.range_by_py   = rby_r;
  assign out_rsp.bearing_by_px = bbx_r;
  assign out_rsp.bearing_by_py = bby_r;
  assign out_rsp.rate_by_px    = rtx_r;
  assign out_rsp.rate_by_py    = rty_r;
  assign out_rsp.zero_range    = zr_r;

  // Port-level view of the handshakes for the attached checker.
  logic chk_in_ready, chk_out_ready;
  assign chk_in_ready  = en;
  assign chk_out_ready = out_rsp.ready;

endmodule

### hdl/rmj_checker.sv
`timescale 1ns / 1ps
// Port-level checker for radar_measurement_jacobian and the bind that attaches it.
// Depends on the top level's handshake signals and result registers.
module rmj_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] range_by_px,
  input logic [WORD_BITS-1:0] range_by_py,
  input logic [WORD_BITS-1:0] bearing_by_px,
  input logic [WORD_BITS-1:0] bearing_by_py,
  input logic [WORD_BITS-1:0] rate_by_px,
  input logic [WORD_BITS-1:0] rate_by_py,
  input logic                 zero_range
);

  logic [6*WORD_BITS:0] payload;
  assign payload = {range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                    rate_by_px, rate_by_py, zero_range};

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(payload))
    else $error("result changed while stalled");

  // Zero range comes with an all-zero Jacobian.
  a_zero_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_range |-> (payload[6*WORD_BITS:1] == '0))
    else $error("zero range with nonzero entries");

  // With the output register empty, the block always takes a request.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused while output is empty");

endmodule

bind radar_measurement_jacobian rmj_checker #(.WORD_BITS(WORD_BITS)) u_rmj_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (chk_in_ready),
  .out_valid    (out_valid_r),
  .out_ready    (chk_out_ready),
  .range_by_px  (rbx_r),
  .range_by_py  (rby_r),
  .bearing_by_px(bbx_r),
  .bearing_by_py(bby_r),
  .rate_by_px   (rtx_r),
  .rate_by_py   (rty_r),
  .zero_range   (zr_r)
);

### tb/tb_radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// Self-checking testbench of radar_measurement_jacobian at WORD_BITS 32, FRAC_BITS 16.
// Depends on rmj_pkg, rmj_if and the block; a built-in fixed-point Jacobian
// calculator predicts results not given by the table; all are checked in request order.
module tb_radar_measurement_jacobian;

  localparam int WB = 32;
  localparam int FB = 16;
  // Pipeline depth; the receiver hold-off and the final wait are sized from it.
  localparam int LATENCY = 4 * WB + 4 * FB + 9;
  localparam longint CYCLE_LIMIT = 64'd600000;

  typedef logic [WB-1:0] word_t;

  typedef struct {
    logic signed [WB-1:0] px, py, vx, vy;
  } state_t;

  typedef struct {
    logic signed [WB-1:0] rpx, rpy, bpx, bpy, tpx, tpy;
    logic                 zr;
  } jac_t;

  // One row of the directed table. Rows whose result can be read off at a
  // glance carry it; the rest are left to the calculator.
  typedef struct {
    state_t s;
    bit     has_exp;
    jac_t   j;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmj_in_if  #(.WORD_BITS(WB)) in_req ();
  rmj_out_if #(.WORD_BITS(WB)) out_rsp ();

  radar_measurement_jacobian #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #6 clk = ~clk;

  jac_t   jac_queue[$];
  int     errors = 0;
  longint cycles = 0;

  // Idling control: percent chances that each side sits out a cycle, plus
  // a long hold-off of the receiver that lets the pipeline fill up.
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  int     hold_cycles = 0;

  // ---------------------------------------------------------------------
  // Fixed-point Jacobian calculator. Works in sign-magnitude form with
  // 128-bit unsigned intermediates; quotients truncate toward zero.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] sqrt_floor(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic word_t clamp_word(bit neg, logic [127:0] mag);
    logic [127:0] half;
    half = 128'd1 << (WB - 1);
    if (neg) begin
      if (mag > half) mag = half;
      return word_t'(-mag);
    end
    if (mag >= half) mag = half - 1;
    return word_t'(mag);
  endfunction

  function automatic logic [127:0] abs_word(logic signed [WB-1:0] v, output bit neg);
    neg = v[WB-1];
    return neg ? 128'(-{1'b1, v}) & ((128'd1 << WB) - 1) : 128'(v);
  endfunction

  function automatic word_t rate_term(logic [127:0] a, logic [127:0] dmag, bit neg,
                                      logic [127:0] s2);
    logic [127:0] t;
    t = ((dmag * a) << FB) / s2;
    if (t[127:64] != 0) return clamp_word(neg, 128'd1 << 64);
    return clamp_word(neg, 128'(sqrt_floor((t * t) / s2)));
  endfunction

  function automatic jac_t jacobian_of(state_t st);
    jac_t         j;
    bit           pn, qn, vxn, vyn, s1, s2, dn;
    logic [127:0] a, b, vx, vy, rsq, m1, m2, dmag;
    a   = abs_word(st.px, pn);
    b   = abs_word(st.py, qn);
    vx  = abs_word(st.vx, vxn);
    vy  = abs_word(st.vy, vyn);
    rsq = a * a + b * b;
    j = '{default: '0};
    if (rsq == 0) begin
      j.zr = 1'b1;
      return j;
    end
    j.rpx = clamp_word(pn, 128'(sqrt_floor(((a * a) << (2 * FB)) / rsq)));
    j.rpy = clamp_word(qn, 128'(sqrt_floor(((b * b) << (2 * FB)) / rsq)));
    j.bpx = clamp_word(!qn, (b << (2 * FB)) / rsq);
    j.bpy = clamp_word(pn, (a << (2 * FB)) / rsq);
    // Cross term D = vx*py - vy*px, kept exact in sign-magnitude form.
    m1 = vx * b;
    s1 = vxn ^ qn;
    m2 = vy * a;
    s2 = !(vyn ^ pn);
    if (s1 == s2) begin
      dmag = m1 + m2;
      dn = s1;
    end else if (m1 >= m2) begin
      dmag = m1 - m2;
      dn = s1;
    end else begin
      dmag = m2 - m1;
      dn = s2;
    end
    j.tpx = rate_term(b, dmag, qn ^ dn, rsq);
    j.tpy = rate_term(a, dmag, pn ^ !dn, rsq);
    return j;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offers one request at a time, idling at random.
  // ---------------------------------------------------------------------
  task automatic send_state(state_t st, jac_t exp_j);
    while ($urandom_range(99) < src_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.pos_x <= st.px;
    in_req.pos_y <= st.py;
    in_req.vel_x <= st.vx;
    in_req.vel_y <= st.vy;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    jac_queue.push_back(exp_j);
  endtask

  function automatic logic signed [WB-1:0] rand_field();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return 32'($signed($urandom_range(255)) - 128);
      2: return 32'($signed($urandom_range(32'h3ffff)) - 32'sh20000);
      3: return 32'($signed($urandom_range(32'hfffff)) - 32'sh80000);
      4: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (jac_queue.size() != 0) @(posedge clk);
  endtask

  task automatic random_states(int count);
    state_t st;
    for (int k = 0; k < count; k++) begin
      st.px = rand_field();
      st.py = rand_field();
      st.vx = rand_field();
      st.vy = rand_field();
      // Now and then put the target exactly at the origin.
      if ($urandom_range(29) == 0) begin
        st.px = '0;
        st.py = '0;
      end
      send_state(st, jacobian_of(st));
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: ready is redrawn every cycle; a hold-off forces it low.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    jac_t e;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (jac_queue.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        e = jac_queue.pop_front();
        if (out_rsp.range_by_px !== e.rpx) begin
          $error("range_by_px: expected %0d, got %0d", e.rpx, out_rsp.range_by_px);
          errors++;
        end
        if (out_rsp.range_by_py !== e.rpy) begin
          $error("range_by_py: expected %0d, got %0d", e.rpy, out_rsp.range_by_py);
          errors++;
        end
        if (out_rsp.bearing_by_px !== e.bpx) begin
          $error("bearing_by_px: expected %0d, got %0d", e.bpx, out_rsp.bearing_by_px);
          errors++;
        end
        if (out_rsp.bearing_by_py !== e.bpy) begin
          $error("bearing_by_py: expected %0d, got %0d", e.bpy, out_rsp.bearing_by_py);
          errors++;
        end
        if (out_rsp.rate_by_px !== e.tpx) begin
          $error("rate_by_px: expected %0d, got %0d", e.tpx, out_rsp.rate_by_px);
          errors++;
        end
        if (out_rsp.rate_by_py !== e.tpy) begin
          $error("rate_by_py: expected %0d, got %0d", e.tpy, out_rsp.rate_by_py);
          errors++;
        end
        if (out_rsp.zero_range !== e.zr) begin
          $error("zero_range: expected %0b, got %0b", e.zr, out_rsp.zero_range);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung pipeline ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    jac_t     zero_j;
    jac_t     e;
    localparam logic signed [WB-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [WB-1:0] MINV = 32'sh80000000;
    localparam logic signed [WB-1:0] ONE = 32'sh00010000;

    in_req.valid = 1'b0;
    in_req.pos_x = '0;
    in_req.pos_y = '0;
    in_req.vel_x = '0;
    in_req.vel_y = '0;
    out_rsp.ready = 1'b0;

    zero_j = '{default: '0};
    zero_j.zr = 1'b1;

    // Zero range, with and without velocity: all entries zero, flag set.
    dir_rows.push_back('{'{0, 0, 0, 0}, 1, zero_j});
    dir_rows.push_back('{'{0, 0, MAXV, MINV}, 1, zero_j});
    // Target one unit out on the x axis, at rest: px/r = 1, py/r2 term 0,
    // px/r2 = 1, no range rate.
    e = '{default: '0};
    e.rpx = ONE;
    e.bpy = ONE;
    dir_rows.push_back('{'{ONE, 0, 0, 0}, 1, e});
    // Same on the y axis: py/r = 1, bearing by px = -1.
    e = '{default: '0};
    e.rpy = ONE;
    e.bpx = -ONE;
    dir_rows.push_back('{'{0, ONE, 0, 0}, 1, e});
    // Smallest nonzero position saturates the bearing entry by py.
    e = '{default: '0};
    e.rpx = ONE;
    e.bpy = MAXV;
    dir_rows.push_back('{'{1, 0, 0, 0}, 1, e});
    e = '{default: '0};
    e.rpx = -ONE;
    e.bpy = MINV;
    dir_rows.push_back('{'{-1, 0, 0, 0}, 1, e});
    // Extremes and mixed signs, left to the calculator.
    dir_rows.push_back('{'{MAXV, MAXV, MAXV, MAXV}, 0, zero_j});
    dir_rows.push_back('{'{MINV, MINV, MINV, MINV}, 0, zero_j});
    dir_rows.push_back('{'{MINV, MAXV, MAXV, MINV}, 0, zero_j});
    dir_rows.push_back('{'{MAXV, MINV, MINV, MAXV}, 0, zero_j});
    dir_rows.push_back('{'{MINV, 0, 0, MAXV}, 0, zero_j});
    dir_rows.push_back('{'{0, MINV, MAXV, 0}, 0, zero_j});
    dir_rows.push_back('{'{1, 1, MAXV, MINV}, 0, zero_j});
    dir_rows.push_back('{'{1, -1, MINV, MAXV}, 0, zero_j});
    dir_rows.push_back('{'{ONE, ONE, ONE, -ONE}, 0, zero_j});
    dir_rows.push_back('{'{3 * ONE, 4 * ONE, -2 * ONE, ONE}, 0, zero_j});
    dir_rows.push_back('{'{-3 * ONE, 4 * ONE, 5 * ONE, 7 * ONE}, 0, zero_j});
    dir_rows.push_back('{'{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 32'shF0F0F0F0},
                         0, zero_j});
    dir_rows.push_back('{'{32'sh12345678, -32'sh00000fff, 32'sh7fff0000, 32'sh0000ffff},
                         0, zero_j});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_state(row.s, row.has_exp ? row.j : jacobian_of(row.s));
    end
    wait_drained();

    // Sender sparse, receiver busy.
    src_idle_pct = 20;
    snk_idle_pct = 49;
    random_states(200);

    // Long receiver stall while requests keep coming, to back the pipe up
    // and stall the input side.
    src_idle_pct = 0;
    hold_cycles = 3 * LATENCY;
    random_states(250);

    // Sender pauses until every predicted result has come back.
    wait_drained();

    src_idle_pct = 49;
    snk_idle_pct = 20;
    random_states(200);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_states(150);

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### radar_measurement_jacobian.f
hdl/rmj_pkg.sv
hdl/rmj_if.sv
hdl/rmj_delay.sv
hdl/rmj_mul.sv
hdl/rmj_div.sv
hdl/rmj_sqrt.sv
hdl/radar_measurement_jacobian.sv
hdl/rmj_checker.sv
tb/tb_radar_measurement_jacobian.sv
